>>> rtl/core/lsst_pkg.sv
// ----------------------------------------------------------------------------
// lsst_pkg: shared types and constants of the limit-switch stroke tracker.
// Holds the flag layout, stroke patterns, error codes, register map and the
// structs that travel between the tracker's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsst_pkg;

    localparam int ANGLE_W = 9;
    localparam int SERVO_W = 8;
    localparam int FLAG_W  = 4;
    localparam int ERR_W   = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 9'd360;

    // Bit positions inside the flag word.
    localparam int FLAG_LEFT_MOVING  = 0;
    localparam int FLAG_RIGHT_SIDE   = 1;
    localparam int FLAG_LEFT_SIDE    = 2;
    localparam int FLAG_RIGHT_MOVING = 3;

    // The six legal stroke positions.
    localparam logic [FLAG_W-1:0] PAT_RM_CENTER = 4'h8;
    localparam logic [FLAG_W-1:0] PAT_RM_RIGHT  = 4'hA;
    localparam logic [FLAG_W-1:0] PAT_RM_LEFT   = 4'hC;
    localparam logic [FLAG_W-1:0] PAT_LM_CENTER = 4'h1;
    localparam logic [FLAG_W-1:0] PAT_LM_RIGHT  = 4'h3;
    localparam logic [FLAG_W-1:0] PAT_LM_LEFT   = 4'h5;

    localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BOTH_DIR     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_DIR       = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_LOCATION = 2'd3;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MAX_ANGLE   = 2'd0;
    localparam logic [1:0] REG_MIN_ANGLE   = 2'd1;
    localparam logic [1:0] REG_SLOW_OFFSET = 2'd2;
    localparam logic [1:0] REG_SERVO_ID    = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] max_angle;
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] slow_offset;
        logic [SERVO_W-1:0] servo_id;
    } cfg_t;

    typedef struct packed {
        logic               goal_valid;
        logic [ANGLE_W-1:0] goal_angle;
        logic [ERR_W-1:0]   error_code;
        logic [FLAG_W-1:0]  flags;
    } step_result_t;

    // Saturates a 10-bit non-negative angle to the legal range.
    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W:0] value);
        logic [ANGLE_W-1:0] result;
        if (value > {1'b0, ANGLE_LIMIT})
        begin
            result = ANGLE_LIMIT;
        end
        else
        begin
            result = value[ANGLE_W-1:0];
        end
        return result;
    endfunction

endpackage

>>> rtl/core/lsst_regs.sv
// ----------------------------------------------------------------------------
// lsst_regs: configuration register file of the stroke tracker.
// APB-style write and read access to the angle and servo registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsst_regs
    import lsst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [ANGLE_W-1:0] max_angle_reg;
    logic [ANGLE_W-1:0] min_angle_reg;
    logic [ANGLE_W-1:0] slow_offset_reg;
    logic [SERVO_W-1:0] servo_id_reg;
    logic               wr_en;
    logic [1:0]         reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg   <= 9'd270;
            min_angle_reg   <= 9'd90;
            slow_offset_reg <= 9'd20;
            servo_id_reg    <= 8'd1;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_MAX_ANGLE:   max_angle_reg   <= pwdata[ANGLE_W-1:0];
                REG_MIN_ANGLE:   min_angle_reg   <= pwdata[ANGLE_W-1:0];
                REG_SLOW_OFFSET: slow_offset_reg <= pwdata[ANGLE_W-1:0];
                REG_SERVO_ID:    servo_id_reg    <= pwdata[SERVO_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MAX_ANGLE:   prdata = {{(DATA_W-ANGLE_W){1'b0}}, max_angle_reg};
            REG_MIN_ANGLE:   prdata = {{(DATA_W-ANGLE_W){1'b0}}, min_angle_reg};
            REG_SLOW_OFFSET: prdata = {{(DATA_W-ANGLE_W){1'b0}}, slow_offset_reg};
            REG_SERVO_ID:    prdata = {{(DATA_W-SERVO_W){1'b0}}, servo_id_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.max_angle   = max_angle_reg;
    assign cfg.min_angle   = min_angle_reg;
    assign cfg.slow_offset = slow_offset_reg;
    assign cfg.servo_id    = servo_id_reg;

endmodule

>>> rtl/core/lsst_step.sv
// ----------------------------------------------------------------------------
// lsst_step: flag update and goal selection for one beat.
// Samples the switch pin that the current stroke position calls for and
// picks the saturated goal angle from the updated position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsst_step
    import lsst_pkg::*;
(
    input  logic [FLAG_W-1:0] flags,
    input  logic              pin0,
    input  logic              pin2,
    input  logic              pin3,
    input  logic              pin4,
    input  cfg_t              cfg,
    output step_result_t      result
);

    logic [FLAG_W-1:0]  nf;
    logic [ERR_W-1:0]   err;
    logic [ANGLE_W:0]   end_minus;
    logic [ANGLE_W:0]   end_plus;

    always_comb
    begin
        nf  = flags;
        err = ERR_NONE;
        case (flags)
            PAT_RM_CENTER: nf[FLAG_RIGHT_SIDE] = pin2;
            PAT_RM_RIGHT:  nf = pin0 ? PAT_LM_RIGHT : flags;
            PAT_LM_RIGHT:  nf[FLAG_RIGHT_SIDE] = ~pin2;
            PAT_LM_CENTER: nf[FLAG_LEFT_SIDE] = pin3;
            PAT_LM_LEFT:   nf = pin4 ? PAT_RM_LEFT : flags;
            PAT_RM_LEFT:   nf[FLAG_LEFT_SIDE] = ~pin3;
            default:
            begin
                if (flags[FLAG_RIGHT_MOVING] && flags[FLAG_LEFT_MOVING])
                begin
                    err = ERR_BOTH_DIR;
                end
                else if (!flags[FLAG_RIGHT_MOVING] && !flags[FLAG_LEFT_MOVING])
                begin
                    err = ERR_NO_DIR;
                end
                else
                begin
                    err = ERR_BAD_LOCATION;
                end
            end
        endcase
    end

    // The pulled-back angle saturates at zero when the offset exceeds max.
    assign end_minus = (cfg.max_angle < cfg.slow_offset) ? '0
                     : {1'b0, cfg.max_angle} - {1'b0, cfg.slow_offset};
    assign end_plus  = {1'b0, cfg.min_angle} + {1'b0, cfg.slow_offset};

    always_comb
    begin
        result.goal_valid = 1'b1;
        result.error_code = err;
        result.flags      = nf;
        case (nf)
            PAT_RM_CENTER: result.goal_angle = clamp_angle({1'b0, cfg.max_angle});
            PAT_RM_RIGHT,
            PAT_RM_LEFT:   result.goal_angle = clamp_angle(end_minus);
            PAT_LM_CENTER: result.goal_angle = clamp_angle({1'b0, cfg.min_angle});
            PAT_LM_RIGHT,
            PAT_LM_LEFT:   result.goal_angle = clamp_angle(end_plus);
            default:
            begin
                result.goal_valid = 1'b0;
                result.goal_angle = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/limit_switch_stroke_tracker.sv
// ----------------------------------------------------------------------------
// limit_switch_stroke_tracker: follows a back-and-forth stroke from four
// limit-switch levels and issues a servo goal angle for every beat.
// Each input beat is taken into an input register, the flag update and goal
// selection run combinationally between it and the output register, and the
// result lands in the output register once that register is free, from
// where the output side takes it. One beat is accepted every cycle as long as
// the output side keeps up; the sustained rate of one beat per cycle is set
// by the loop through the stroke flag register. A stalled result holds the
// pipeline, and the input stalls only when both registers are full.
// Once the flags reach an illegal pattern they stay there and every result
// reports the matching error code with no goal until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module limit_switch_stroke_tracker
    import lsst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               pin0_level,
    input  logic               pin2_level,
    input  logic               pin3_level,
    input  logic               pin4_level,
    // Output channel.
    output logic               out_valid,
    input  logic               out_stall,
    output logic               goal_valid,
    output logic [ANGLE_W-1:0] goal_angle,
    output logic [SERVO_W-1:0] target_servo,
    output logic [ERR_W-1:0]   error_code,
    output logic [FLAG_W-1:0]  flag_pattern,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t         cfg;
    step_result_t step_res;

    // Input register stage.
    logic s1_valid_reg;
    logic s1_valid_next;
    logic pin0_reg;
    logic pin2_reg;
    logic pin3_reg;
    logic pin4_reg;

    // Stroke state.
    logic [FLAG_W-1:0] flags_reg;

    // Output register stage.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               goal_valid_reg;
    logic [ANGLE_W-1:0] goal_angle_reg;
    logic [SERVO_W-1:0] target_servo_reg;
    logic [ERR_W-1:0]   error_code_reg;
    logic [FLAG_W-1:0]  flag_pattern_reg;

    logic in_accept;
    logic advance;
    logic s1_fire;

    lsst_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsst_step u_step
    (
        .flags  (flags_reg),
        .pin0   (pin0_reg),
        .pin2   (pin2_reg),
        .pin3   (pin3_reg),
        .pin4   (pin4_reg),
        .cfg    (cfg),
        .result (step_res)
    );

    // The output register frees up whenever it is empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !advance);
    assign out_valid_next = s1_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= PAT_RM_CENTER;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                flags_reg <= step_res.flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pin0_reg <= pin0_level;
            pin2_reg <= pin2_level;
            pin3_reg <= pin3_level;
            pin4_reg <= pin4_level;
        end
        if (s1_fire)
        begin
            goal_valid_reg   <= step_res.goal_valid;
            goal_angle_reg   <= step_res.goal_angle;
            target_servo_reg <= cfg.servo_id;
            error_code_reg   <= step_res.error_code;
            flag_pattern_reg <= step_res.flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign goal_valid   = goal_valid_reg;
    assign goal_angle   = goal_angle_reg;
    assign target_servo = target_servo_reg;
    assign error_code   = error_code_reg;
    assign flag_pattern = flag_pattern_reg;

    // An error result never carries a goal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (error_code_reg != ERR_NONE)) |-> !goal_valid_reg)
        else $error("error result carries a goal");

    // A delivered goal is always inside the legal angle range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (goal_angle_reg <= ANGLE_LIMIT))
        else $error("goal angle above limit");

    // The stroke state always matches the flags of the last result produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (flags_reg == flag_pattern_reg))
        else $error("stroke flags out of step with result");

    // An error leaves the stroke flags untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (step_res.error_code != ERR_NONE)) |=> $stable(flags_reg))
        else $error("flags changed on an error beat");

endmodule
